[design/thac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thac_pkg
// Shared widths, codes and control types for the timing histogram accumulator.
// ----------------------------------------------------------------------------
package thac_pkg;

	localparam int INDEX_W = 4;
	localparam int VALUE_W = 8;
	localparam int TIME_W  = 24;
	localparam int SQ_W    = 2 * TIME_W;
	localparam int SUM_W   = 64;
	localparam int CNT_W   = 32;
	localparam int CELL_W  = SUM_W + SUM_W + CNT_W;

	localparam logic MODE_ACC  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

endpackage
`default_nettype wire

[design/timing_histogram_accumulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// timing_histogram_accumulator
// Per position/value timing statistics with saturating sums and totals.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. mode 0 adds timing,
// its square and one hit to cell (byte_index, byte_value) and bumps the
// totals; mode 1 reads that cell and the totals. Out-of-range cells are
// skipped on accumulate and read back as zero.
// Each word passes through accept with RAM read, square of the tick
// count, then read-modify-write of the cell store. busy falls again after
// the update cycle, so a new word is only taken once the last is through.
// A read result appears with done high for exactly one cycle, in the cycle
// after the update; the receiver cannot stall it and a new word may be
// taken in that same cycle.
// After reset the cell store is cleared by a sweep over all POSITIONS*VALUES
// cells (4096 by default), one cell a cycle, with busy held high.
// ----------------------------------------------------------------------------
module timing_histogram_accumulator #(
	parameter int POSITIONS   = 16,
	parameter int VALUES      = 256,
	parameter int TIMING_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          mode,
	input  wire logic [thac_pkg::INDEX_W-1:0]  byte_index,
	input  wire logic [thac_pkg::VALUE_W-1:0]  byte_value,
	input  wire logic [thac_pkg::TIME_W-1:0]   timing,
	output logic                               done,
	output logic      [thac_pkg::SUM_W-1:0]    sum_time,
	output logic      [thac_pkg::SUM_W-1:0]    sum_square,
	output logic      [thac_pkg::CNT_W-1:0]    hits,
	output logic      [thac_pkg::CNT_W-1:0]    total_count,
	output logic      [thac_pkg::SUM_W-1:0]    total_time
);

	thac_pkg::cmd_t cmd;
	thac_pkg::sts_t sts;

	thac_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	thac_dpath #(
		.POSITIONS  (POSITIONS),
		.VALUES     (VALUES),
		.TIMING_BITS(TIMING_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.byte_index (byte_index),
		.byte_value (byte_value),
		.timing     (timing),
		.done       (done),
		.sum_time   (sum_time),
		.sum_square (sum_square),
		.hits       (hits),
		.total_count(total_count),
		.total_time (total_time)
	);

	// a result only follows an update cycle
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.update))
		else $error("result strobe without preceding update");

	// an accepted word keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// the update cycle always hands back to idle
	a_update_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> !busy)
		else $error("block not idle after update");

	// no sweep write while a word is in progress
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !(cmd.capture || cmd.update))
		else $error("clearing overlaps word processing");

endmodule
`default_nettype wire

[design/thac_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thac_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module thac_ram #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[design/thac_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thac_ctrl
// Sequencer: clearing sweep after reset, then fetch, square and update for
// each accepted word.
// ----------------------------------------------------------------------------
module thac_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire thac_pkg::sts_t sts,
	output thac_pkg::cmd_t     cmd,
	output logic               busy
);

	thac_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thac_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			thac_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = thac_pkg::ST_IDLE;
				end
			end
			thac_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = thac_pkg::ST_MUL;
				end
			end
			thac_pkg::ST_MUL: begin
				state_d = thac_pkg::ST_UPDATE;
			end
			thac_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = thac_pkg::ST_IDLE;
			end
			default: begin
				state_d = thac_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

[design/thac_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thac_dpath
// Cell store, squarer, saturating adders, totals and result registers.
// ----------------------------------------------------------------------------
module thac_dpath #(
	parameter int POSITIONS   = 16,
	parameter int VALUES      = 256,
	parameter int TIMING_BITS = 24
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire thac_pkg::cmd_t                     cmd,
	output thac_pkg::sts_t                          sts,
	input  wire logic                               mode,
	input  wire logic [thac_pkg::INDEX_W-1:0]       byte_index,
	input  wire logic [thac_pkg::VALUE_W-1:0]       byte_value,
	input  wire logic [thac_pkg::TIME_W-1:0]        timing,
	output logic                                    done,
	output logic      [thac_pkg::SUM_W-1:0]         sum_time,
	output logic      [thac_pkg::SUM_W-1:0]         sum_square,
	output logic      [thac_pkg::CNT_W-1:0]         hits,
	output logic      [thac_pkg::CNT_W-1:0]         total_count,
	output logic      [thac_pkg::SUM_W-1:0]         total_time
);

	localparam int CELLS  = POSITIONS * VALUES;
	localparam int ADDR_W = $clog2(CELLS);
	localparam logic [thac_pkg::TIME_W-1:0] TMASK = (TIMING_BITS >= thac_pkg::TIME_W) ?
		{thac_pkg::TIME_W{1'b1}} :
		thac_pkg::TIME_W'((33'd1 << TIMING_BITS) - 33'd1);

	function automatic logic [thac_pkg::SUM_W-1:0] sat_add(
		input logic [thac_pkg::SUM_W-1:0] a,
		input logic [thac_pkg::SUM_W-1:0] b
	);
		logic [thac_pkg::SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[thac_pkg::SUM_W] ? {thac_pkg::SUM_W{1'b1}} : s[thac_pkg::SUM_W-1:0];
	endfunction

	function automatic logic [thac_pkg::CNT_W-1:0] sat_inc(
		input logic [thac_pkg::CNT_W-1:0] a
	);
		return (&a) ? a : a + thac_pkg::CNT_W'(1);
	endfunction

	logic [ADDR_W-1:0]            clr_q;
	logic                         mode_q;
	logic                         ok_q;
	logic [ADDR_W-1:0]            addr_q;
	logic [thac_pkg::TIME_W-1:0]  t_q;
	logic [thac_pkg::SQ_W-1:0]    sq_q;
	logic [thac_pkg::CNT_W-1:0]   cnt_total_q;
	logic [thac_pkg::SUM_W-1:0]   time_total_q;

	logic                         in_ok;
	logic [ADDR_W-1:0]            in_addr;
	logic [thac_pkg::CELL_W-1:0]  rdata;
	logic [thac_pkg::SUM_W-1:0]   cell_time, cell_sq, new_time, new_sq;
	logic [thac_pkg::CNT_W-1:0]   cell_hits, new_hits;
	logic                         commit;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [thac_pkg::CELL_W-1:0]  ram_wdata;

	assign in_ok   = (32'(byte_index) < POSITIONS) && (32'(byte_value) < VALUES);
	assign in_addr = ADDR_W'(32'(byte_index) * VALUES + 32'(byte_value));

	assign {cell_time, cell_sq, cell_hits} = rdata;
	assign new_time = sat_add(cell_time, thac_pkg::SUM_W'(t_q));
	assign new_sq   = sat_add(cell_sq, thac_pkg::SUM_W'(sq_q));
	assign new_hits = sat_inc(cell_hits);

	assign commit    = cmd.update && (mode_q == thac_pkg::MODE_ACC) && ok_q;
	assign ram_we    = cmd.clear_step || commit;
	assign ram_waddr = cmd.clear_step ? clr_q : addr_q;
	assign ram_wdata = cmd.clear_step ? '0 : {new_time, new_sq, new_hits};

	assign sts.clear_last = (clr_q == ADDR_W'(CELLS - 1));

	thac_ram #(
		.WIDTH(thac_pkg::CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.capture),
		.raddr(in_addr),
		.rdata(rdata)
	);

	// control state: sweep pointer, totals and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			cnt_total_q  <= '0;
			time_total_q <= '0;
			done         <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (commit) begin
				cnt_total_q  <= sat_inc(cnt_total_q);
				time_total_q <= sat_add(time_total_q, thac_pkg::SUM_W'(t_q));
			end
			done <= cmd.update && (mode_q == thac_pkg::MODE_READ);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			ok_q   <= in_ok;
			addr_q <= in_addr;
			t_q    <= timing & TMASK;
		end
		sq_q <= thac_pkg::SQ_W'(t_q) * thac_pkg::SQ_W'(t_q);
		if (cmd.update && (mode_q == thac_pkg::MODE_READ)) begin
			sum_time    <= ok_q ? cell_time : '0;
			sum_square  <= ok_q ? cell_sq : '0;
			hits        <= ok_q ? cell_hits : '0;
			total_count <= cnt_total_q;
			total_time  <= time_total_q;
		end
	end

endmodule
`default_nettype wire

[bench/thac_checker.sv]
// ----------------------------------------------------------------------------
// thac_checker
// Watches the command and result channels of the timing histogram
// accumulator, keeps its own copy of the cell store and totals, and compares
// every cell report against the value predicted when the read was taken.
// ----------------------------------------------------------------------------
module thac_checker #(
	parameter int POSITIONS   = 16,
	parameter int VALUES      = 256,
	parameter int TIMING_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic                          mode,
	input  wire logic [thac_pkg::INDEX_W-1:0]  byte_index,
	input  wire logic [thac_pkg::VALUE_W-1:0]  byte_value,
	input  wire logic [thac_pkg::TIME_W-1:0]   timing,
	input  wire logic                          done,
	input  wire logic [thac_pkg::SUM_W-1:0]    sum_time,
	input  wire logic [thac_pkg::SUM_W-1:0]    sum_square,
	input  wire logic [thac_pkg::CNT_W-1:0]    hits,
	input  wire logic [thac_pkg::CNT_W-1:0]    total_count,
	input  wire logic [thac_pkg::SUM_W-1:0]    total_time,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 reports_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import thac_pkg::*;

	localparam int CELLS = POSITIONS * VALUES;

	typedef struct packed {
		logic [SUM_W-1:0] sum_time;
		logic [SUM_W-1:0] sum_square;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] total_count;
		logic [SUM_W-1:0] total_time;
	} cell_report_t;

	logic [SUM_W-1:0] ticks_by_cell   [CELLS];
	logic [SUM_W-1:0] squares_by_cell [CELLS];
	logic [CNT_W-1:0] hits_by_cell    [CELLS];
	logic [CNT_W-1:0] samples_seen;
	logic [SUM_W-1:0] ticks_seen;
	cell_report_t     reports_due[$];

	function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] bump_clamped(input logic [CNT_W-1:0] a);
		return (a == '1) ? a : a + 1'b1;
	endfunction

	task automatic check_field(input string field, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h, got %0h", $realtime, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int           slot;
		logic         in_range;
		logic [SUM_W-1:0] ticks;
		cell_report_t due;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				ticks_by_cell[i]   = '0;
				squares_by_cell[i] = '0;
				hits_by_cell[i]    = '0;
			end
			samples_seen = '0;
			ticks_seen   = '0;
			reports_due.delete();
			mismatches      = 0;
			reports_checked = 0;
		end else begin
			// retire the report on the bus before taking the next word
			if (done) begin
				if (reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: cell report with no read outstanding", $realtime);
				end else begin
					due = reports_due.pop_front();
					check_field("sum_time", due.sum_time, sum_time);
					check_field("sum_square", due.sum_square, sum_square);
					check_field("hits", SUM_W'(due.hits), SUM_W'(hits));
					check_field("total_count", SUM_W'(due.total_count), SUM_W'(total_count));
					check_field("total_time", due.total_time, total_time);
					reports_checked++;
				end
			end
			if (start && !busy) begin
				in_range = (int'(byte_index) < POSITIONS) && (int'(byte_value) < VALUES);
				slot     = in_range ? int'(byte_index) * VALUES + int'(byte_value) : 0;
				if (mode == MODE_ACC) begin
					if (in_range) begin
						ticks = SUM_W'(timing) & ((SUM_W'(1) << TIMING_BITS) - 1);
						ticks_by_cell[slot]   = add_clamped(ticks_by_cell[slot], ticks);
						squares_by_cell[slot] = add_clamped(squares_by_cell[slot], ticks * ticks);
						hits_by_cell[slot]    = bump_clamped(hits_by_cell[slot]);
						samples_seen          = bump_clamped(samples_seen);
						ticks_seen            = add_clamped(ticks_seen, ticks);
					end
				end else begin
					due.sum_time    = in_range ? ticks_by_cell[slot] : '0;
					due.sum_square  = in_range ? squares_by_cell[slot] : '0;
					due.hits        = in_range ? hits_by_cell[slot] : '0;
					due.total_count = samples_seen;
					due.total_time  = ticks_seen;
					reports_due.push_back(due);
				end
			end
		end
		pending = reports_due.size();
	end

endmodule

[bench/tb_timing_histogram_accumulator.sv]
// ----------------------------------------------------------------------------
// tb_timing_histogram_accumulator
// Drives accumulate and read words into the histogram accumulator with
// random idle bursts, and leaves all prediction and comparison to the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_timing_histogram_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	import thac_pkg::*;

	localparam int RANDOM_WORDS = 850;
	localparam int STEADY_WORDS = 150;
	localparam int HOT_CELLS    = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam logic [TIME_W-1:0] TICK_MAX = '1;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic               mode       = MODE_ACC;
	logic [INDEX_W-1:0] byte_index = '0;
	logic [VALUE_W-1:0] byte_value = '0;
	logic [TIME_W-1:0]  timing     = '0;

	wire logic             busy;
	wire logic             done;
	wire logic [SUM_W-1:0] sum_time;
	wire logic [SUM_W-1:0] sum_square;
	wire logic [CNT_W-1:0] hits;
	wire logic [CNT_W-1:0] total_count;
	wire logic [SUM_W-1:0] total_time;

	int mismatches;
	int pending;
	int reports_checked;

	int          acc_words  = 0;
	int          read_words = 0;
	bit          steady     = 1'b0;
	int unsigned cycles     = 0;

	logic [INDEX_W-1:0] hot_index [HOT_CELLS];
	logic [VALUE_W-1:0] hot_value [HOT_CELLS];

	always #1 clk = ~clk;

	timing_histogram_accumulator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.byte_index  (byte_index),
		.byte_value  (byte_value),
		.timing      (timing),
		.done        (done),
		.sum_time    (sum_time),
		.sum_square  (sum_square),
		.hits        (hits),
		.total_count (total_count),
		.total_time  (total_time)
	);

	thac_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.byte_index      (byte_index),
		.byte_value      (byte_value),
		.timing          (timing),
		.done            (done),
		.sum_time        (sum_time),
		.sum_square      (sum_square),
		.hits            (hits),
		.total_count     (total_count),
		.total_time      (total_time),
		.mismatches      (mismatches),
		.pending         (pending),
		.reports_checked (reports_checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d reports outstanding",
				cycles, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// hold the word until the block takes it, with an optional idle burst first
	task automatic send_word(input logic m, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] val, input logic [TIME_W-1:0] tick);
		if (!steady && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		start      <= 1'b1;
		mode       <= m;
		byte_index <= idx;
		byte_value <= val;
		timing     <= tick;
		do @(posedge clk); while (busy);
		if (m == MODE_ACC)
			acc_words++;
		else
			read_words++;
	endtask

	function automatic logic [TIME_W-1:0] pick_ticks();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return TICK_MAX;
			2:       return TIME_W'($urandom_range(0, 255));
			default: return TIME_W'($urandom());
		endcase
	endfunction

	initial begin
		int  slot;
		int  fails;
		logic m;
		logic [INDEX_W-1:0] idx;
		logic [VALUE_W-1:0] val;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// corner cells, tick extremes and alternating bit patterns
		send_word(MODE_READ, 4'd0, 8'd0, '0);
		send_word(MODE_ACC, 4'd0, 8'd0, '0);
		send_word(MODE_ACC, 4'd15, 8'd255, TICK_MAX);
		send_word(MODE_ACC, 4'd0, 8'd255, TICK_MAX);
		send_word(MODE_ACC, 4'd15, 8'd0, 24'd1);
		send_word(MODE_READ, 4'd0, 8'd0, TICK_MAX);
		send_word(MODE_READ, 4'd15, 8'd255, '0);
		send_word(MODE_READ, 4'd0, 8'd255, '0);
		send_word(MODE_READ, 4'd15, 8'd0, '0);
		send_word(MODE_ACC, 4'd15, 8'd255, TICK_MAX);
		send_word(MODE_ACC, 4'd15, 8'd255, TICK_MAX);
		send_word(MODE_READ, 4'd15, 8'd255, '0);
		send_word(MODE_ACC, 4'd5, 8'hA5, 24'hAAAAAA);
		send_word(MODE_ACC, 4'd10, 8'h5A, 24'h555555);
		send_word(MODE_ACC, 4'd5, 8'hA5, 24'h555555);
		send_word(MODE_READ, 4'd5, 8'hA5, '0);
		send_word(MODE_READ, 4'd10, 8'h5A, '0);
		send_word(MODE_READ, 4'd7, 8'h3C, '0);
		send_word(MODE_READ, 4'd7, 8'h3C, '0);

		hot_index[0] = 4'd0;  hot_value[0] = 8'd0;
		hot_index[1] = 4'd15; hot_value[1] = 8'd255;
		hot_index[2] = 4'd0;  hot_value[2] = 8'd255;
		hot_index[3] = 4'd15; hot_value[3] = 8'd0;
		for (int i = 4; i < HOT_CELLS; i++) begin
			hot_index[i] = INDEX_W'($urandom());
			hot_value[i] = VALUE_W'($urandom());
		end

		// concentrate on a few cells so reads see deep sums
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			steady = (i >= RANDOM_WORDS - STEADY_WORDS);
			if ($urandom_range(0, 9) < 7) begin
				slot = $urandom_range(0, HOT_CELLS - 1);
				idx  = hot_index[slot];
				val  = hot_value[slot];
			end else begin
				idx = INDEX_W'($urandom());
				val = VALUE_W'($urandom());
			end
			m = ($urandom_range(0, 9) < 3) ? MODE_READ : MODE_ACC;
			send_word(m, idx, val, pick_ticks());
		end
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);

		fails = mismatches + pending;
		$display("Sent %0d accumulate and %0d read words over %0d hot cells and random cells",
			acc_words, read_words, HOT_CELLS);
		$display("Compared %0d cell reports, %0d field mismatches, %0d reports left over",
			reports_checked, mismatches, pending);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
design/thac_pkg.sv
design/thac_ram.sv
design/thac_ctrl.sv
design/thac_dpath.sv
design/timing_histogram_accumulator.sv
bench/thac_checker.sv
bench/tb_timing_histogram_accumulator.sv
